// ===== design/mcdr_pkg.sv =====
// Shared types and constants for the motor command dispatcher with ramp drive.
// No dependencies; imported by the configuration channel interface and the core.
package mcdr_pkg;

  // Command and mode codes
  localparam logic [2:0] MODE_STOP       = 3'd0;
  localparam logic [2:0] MODE_RIGHT      = 3'd1;
  localparam logic [2:0] MODE_LEFT       = 3'd2;
  localparam logic [2:0] MODE_RAMP       = 3'd3;
  localparam logic [2:0] CMD_CLEAR_LATCH = 3'd4;

  // Safety states
  localparam logic [1:0] SAFE_NORMAL = 2'd0;
  localparam logic [1:0] SAFE_EMERG  = 2'd1;

  // Motor directions
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  // LED colors
  localparam logic [2:0] LED_OFF    = 3'd0;
  localparam logic [2:0] LED_RED    = 3'd1;
  localparam logic [2:0] LED_GREEN  = 3'd2;
  localparam logic [2:0] LED_BLUE   = 3'd3;
  localparam logic [2:0] LED_YELLOW = 3'd4;

  // Configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DIV  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SPD  = 2'd2;
  localparam logic [7:0] RAMP_DIV_RESET = 8'd10;
  localparam logic [7:0] BLINK_HP_RESET = 8'd50;
  localparam logic [6:0] FULL_SPD_RESET = 7'd100;

  // One input word
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] cmd_code;
    logic [1:0] safety_state;
  } in_word_t;

  // One result word
  typedef struct packed {
    logic       motor_write;
    logic [1:0] motor_dir;
    logic [6:0] motor_speed;
    logic       led_write;
    logic [2:0] led_color;
    logic       clear_emergency;
  } out_word_t;

endpackage

// ===== design/mcdr_if.sv =====
// Valid/ready channel interfaces for the motor command dispatcher.
// Depends on mcdr_pkg for the configuration index width.
interface mcdr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] cmd_code;
  logic [1:0] safety_state;
  modport source (output valid, output cmd_valid, output cmd_code, output safety_state,
                  input ready);
  modport sink (input valid, input cmd_valid, input cmd_code, input safety_state,
                output ready);
endinterface

interface mcdr_out_if;
  logic       valid;
  logic       ready;
  logic       motor_write;
  logic [1:0] motor_dir;
  logic [6:0] motor_speed;
  logic       led_write;
  logic [2:0] led_color;
  logic       clear_emergency;
  modport source (output valid, output motor_write, output motor_dir, output motor_speed,
                  output led_write, output led_color, output clear_emergency,
                  input ready);
  modport sink (input valid, input motor_write, input motor_dir, input motor_speed,
                input led_write, input led_color, input clear_emergency,
                output ready);
endinterface

interface mcdr_cfg_if import mcdr_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/motor_command_dispatcher_ramp_core.sv =====
// Motor command dispatcher with ramp drive: input register, dispatch logic, result register.
// Depends on mcdr_pkg and the channel interfaces in mcdr_if.sv.
//
// Each input word is one tick and yields exactly one result word. The block takes one
// word per clock while the result side keeps up: a word sits in the input register, where
// the dispatch and ramp logic computes the result and updates the mode, ramp and blink
// counters in the same cycle, and is then held in the result register until taken.
// Configuration writes are always accepted and take effect on the next word processed.
module motor_command_dispatcher_ramp_core import mcdr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mcdr_in_if.sink    in_ch,
  mcdr_out_if.source out_ch,
  mcdr_cfg_if.sink   cfg
);

  // Configuration registers
  logic [7:0] ramp_tick_divide;
  logic [7:0] blink_half_period;
  logic [6:0] full_speed;

  // Tick state
  logic [2:0] active_mode;
  logic [6:0] ramp_speed;
  logic [7:0] ramp_prescale;
  logic [7:0] blink_count;
  logic       led_phase;

  // Pipeline registers
  logic      in_full;
  in_word_t  in_word;
  logic      out_full;
  out_word_t out_word;

  logic      out_free;
  logic      advance;

  // Next-state and result values
  logic [2:0] active_mode_next;
  logic [6:0] ramp_speed_next;
  logic [7:0] ramp_prescale_next;
  logic [7:0] blink_count_next;
  logic       led_phase_next;
  out_word_t  result;

  logic       normal;
  logic       emerg;
  logic [7:0] div_inc;
  logic       div_step;
  logic [6:0] spd_inc;
  logic [7:0] blink_inc;
  logic       blink_toggle;

  // Handshakes
  assign out_free     = !out_full || out_ch.ready;
  assign advance      = in_full && out_free;
  assign in_ch.ready  = !in_full || out_free;
  assign cfg.ready    = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_tick_divide  <= RAMP_DIV_RESET;
      blink_half_period <= BLINK_HP_RESET;
      full_speed        <= FULL_SPD_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_RAMP_DIV: ramp_tick_divide  <= cfg.data;
        CFG_BLINK_HP: blink_half_period <= cfg.data;
        CFG_FULL_SPD: full_speed        <= cfg.data[6:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ch.ready) begin
      in_full <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_word.cmd_valid    <= in_ch.cmd_valid;
      in_word.cmd_code     <= in_ch.cmd_code;
      in_word.safety_state <= in_ch.safety_state;
    end
  end

  // Dispatch, fixed drives and ramp drive for one tick
  always_comb begin
    normal = (in_word.safety_state == SAFE_NORMAL);
    emerg  = (in_word.safety_state == SAFE_EMERG);
    result = '0;

    // Dispatch: a latch-clear command selects stop and clears the latch
    active_mode_next = active_mode;
    if (in_word.cmd_valid) begin
      if (in_word.cmd_code == CMD_CLEAR_LATCH) begin
        active_mode_next       = MODE_STOP;
        result.clear_emergency = 1'b1;
      end else begin
        active_mode_next = in_word.cmd_code;
      end
    end
    if (emerg) begin
      active_mode_next = MODE_STOP;
    end

    // Ramp counters
    div_inc      = ramp_prescale + 8'd1;
    div_step     = (div_inc >= ramp_tick_divide);
    spd_inc      = (div_step && (ramp_speed < full_speed)) ? ramp_speed + 7'd1 : ramp_speed;
    blink_inc    = blink_count + 8'd1;
    blink_toggle = (blink_inc >= blink_half_period);

    ramp_speed_next    = 7'd0;
    ramp_prescale_next = 8'd0;
    blink_count_next   = blink_count;
    led_phase_next     = led_phase;

    priority if (emerg) begin
      result.motor_write = 1'b1;
      result.motor_dir   = DIR_STOP;
      result.led_write   = 1'b1;
      result.led_color   = LED_RED;
    end else if (active_mode_next == MODE_STOP) begin
      result.motor_write = 1'b1;
      result.motor_dir   = DIR_STOP;
      result.led_write   = 1'b1;
      result.led_color   = LED_BLUE;
    end else if (normal && active_mode_next == MODE_RIGHT) begin
      result.motor_write = 1'b1;
      result.motor_dir   = DIR_FWD;
      result.motor_speed = full_speed;
      result.led_write   = 1'b1;
      result.led_color   = LED_GREEN;
    end else if (normal && active_mode_next == MODE_LEFT) begin
      result.motor_write = 1'b1;
      result.motor_dir   = DIR_REV;
      result.motor_speed = full_speed;
      result.led_write   = 1'b1;
      result.led_color   = LED_YELLOW;
    end else if (normal && active_mode_next == MODE_RAMP) begin
      ramp_prescale_next = div_step ? 8'd0 : div_inc;
      ramp_speed_next    = (spd_inc > full_speed) ? full_speed : spd_inc;
      result.motor_write = 1'b1;
      result.motor_dir   = DIR_FWD;
      result.motor_speed = ramp_speed_next;
      blink_count_next   = blink_toggle ? 8'd0 : blink_inc;
      led_phase_next     = led_phase ^ blink_toggle;
      result.led_write   = blink_toggle;
      result.led_color   = (blink_toggle && led_phase_next) ? LED_RED : LED_OFF;
    end else begin
      // Non-normal state with a drive mode, or an unknown mode: nothing issued
    end
  end

  // Tick state update
  always_ff @(posedge clk) begin
    if (rst) begin
      active_mode   <= MODE_STOP;
      ramp_speed    <= 7'd0;
      ramp_prescale <= 8'd0;
      blink_count   <= 8'd0;
      led_phase     <= 1'b0;
    end else if (advance) begin
      active_mode   <= active_mode_next;
      ramp_speed    <= ramp_speed_next;
      ramp_prescale <= ramp_prescale_next;
      blink_count   <= blink_count_next;
      led_phase     <= led_phase_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_free) begin
      out_full <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

  assign out_ch.valid           = out_full;
  assign out_ch.motor_write     = out_word.motor_write;
  assign out_ch.motor_dir       = out_word.motor_dir;
  assign out_ch.motor_speed     = out_word.motor_speed;
  assign out_ch.led_write       = out_word.led_write;
  assign out_ch.led_color       = out_word.led_color;
  assign out_ch.clear_emergency = out_word.clear_emergency;

  // Outside ramp mode the ramp speed and prescaler are always clear.
  assert property (@(posedge clk) disable iff (rst)
    (active_mode != MODE_RAMP) |-> (ramp_speed == 7'd0 && ramp_prescale == 8'd0))
    else $error("ramp state not cleared outside ramp mode");

  // An emergency clear always comes with a stop command and a blue or red LED.
  assert property (@(posedge clk) disable iff (rst)
    (out_full && out_word.clear_emergency) |->
      (out_word.motor_write && out_word.motor_dir == DIR_STOP && out_word.led_write &&
       (out_word.led_color == LED_BLUE || out_word.led_color == LED_RED)))
    else $error("emergency clear without stop and blue or red LED");

  // A tick processed in the emergency state leaves the mode at stop.
  assert property (@(posedge clk) disable iff (rst)
    (advance && emerg) |=> (active_mode == MODE_STOP))
    else $error("mode not forced to stop in emergency");

  // Reverse drive only ever shows yellow.
  assert property (@(posedge clk) disable iff (rst)
    (out_full && out_word.motor_dir == DIR_REV) |->
      (out_word.led_write && out_word.led_color == LED_YELLOW))
    else $error("reverse drive without yellow LED");

endmodule
